// ----- hw/rtl/particle_physics_step_macros.svh -----
// Assertion macros for the particle step block.
// Included by the top level; no other dependencies.
`ifndef PARTICLE_PHYSICS_STEP_MACROS_SVH
`define PARTICLE_PHYSICS_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/pps_pkg.sv -----
// Package for the particle step block: payload types, opcodes,
// register indexes, controller states and datapath commands.
package pps_pkg;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_out;

    localparam logic [1:0] OP_ADD_FORCE = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_CLEAR_VEL = 2'd2;
    localparam logic [1:0] OP_SET_POS   = 2'd3;

    localparam logic [2:0] REG_USE_LAMINAR = 3'd0;
    localparam logic [2:0] REG_WEIGHT      = 3'd1;
    localparam logic [2:0] REG_DRAG        = 3'd2;
    localparam logic [2:0] REG_FRICTION    = 3'd3;
    localparam logic [2:0] REG_TIME_STEP   = 3'd4;
    localparam logic [2:0] REG_INV_MASS    = 3'd5;
    localparam logic [2:0] REG_FLOOR       = 3'd6;

    localparam logic signed [31:0] Q_HUNDREDTH = 32'sd655;
    localparam logic signed [31:0] Q_CEILING   = 32'sd327680;
    localparam logic signed [31:0] Q_SIDE_WALL = 32'sd425984;
    localparam logic signed [31:0] Q_BACK_WALL = 32'sd983040;

    // Micro-step of the per-axis tick sequence.
    typedef enum logic [3:0] {
        US_DRAG1 = 4'd0,
        US_DRAG2 = 4'd1,
        US_DRAG3 = 4'd2,
        US_ACCEL = 4'd3,
        US_AD    = 4'd4,
        US_VEL   = 4'd5,
        US_VDT   = 4'd6,
        US_HALF  = 4'd7,
        US_POS   = 4'd8
    } t_ustep;

    typedef struct packed {
        logic       load_op;
        logic       weight;
        logic       axis_step;
        t_ustep     ustep;
        logic [1:0] axis;
        logic       walls;
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WEIGHT = 5'b00010,
        ST_AXIS   = 5'b00100,
        ST_WALLS  = 5'b01000,
        ST_OUT    = 5'b10000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- hw/rtl/pps_datapath.sv -----
// Datapath of the particle step block: state vectors, registers and one
// shared 32x32 multiplier with rounding. Depends on pps_pkg.
module pps_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_load,
    input  pps_pkg::t_in      i_item,
    input  pps_pkg::t_cmd     i_cmd,
    output logic [1:0]        o_opcode,
    output pps_pkg::t_out     o_result
);

    logic               r_laminar;
    logic [30:0]        r_weight, r_drag, r_fric, r_dt, r_imass;
    logic signed [31:0] r_floor;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_frc [3];
    logic signed [31:0] r_vec [3];
    logic [1:0]         r_op;
    logic signed [31:0] r_m, r_a, r_ad, r_v, r_vdt;
    logic signed [31:0] r_prod;

    logic signed [31:0] w_ma, w_mb;
    logic [4:0]         w_sh;
    logic signed [63:0] w_p;
    logic signed [65:0] w_r;
    logic signed [31:0] w_av, w_v, w_pm;
    logic signed [31:0] n_pos [3];
    logic signed [31:0] n_vel [3];
    logic signed [31:0] n_frc [3];

    // Shared multiplier operands per micro-step.
    always_comb begin
        w_v  = r_vel[i_cmd.axis];
        w_av = (w_v < 0) ? pps_pkg::sat32(-66'(w_v)) : w_v;
        w_ma = '0;
        w_mb = '0;
        w_sh = 5'd16;
        case (i_cmd.ustep)
            pps_pkg::US_DRAG1: begin
                if (r_laminar) begin
                    w_ma = {1'b0, r_drag};
                    w_mb = w_v;
                end else begin
                    w_ma = w_v;
                    w_mb = w_av;
                end
            end
            pps_pkg::US_DRAG2: begin
                w_ma = {1'b0, r_drag};
                w_mb = r_prod;
            end
            pps_pkg::US_ACCEL: begin
                w_ma = r_frc[i_cmd.axis];
                w_mb = {1'b0, r_imass};
            end
            pps_pkg::US_AD: begin
                w_ma = r_a;
                w_mb = {1'b0, r_dt};
            end
            pps_pkg::US_VDT: begin
                w_ma = r_v;
                w_mb = {1'b0, r_dt};
            end
            pps_pkg::US_HALF: begin
                w_ma = r_ad;
                w_mb = {1'b0, r_dt};
                w_sh = 5'd17;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_p  = w_ma * w_mb;
        // Floor of (p + half) >> s gives round half up for either sign.
        w_r  = (66'(w_p) + (66'sd1 <<< (w_sh - 5'd1))) >>> w_sh;
        w_pm = pps_pkg::sat32(w_r);
    end

    always_comb begin
        logic signed [31:0] d;
        for (int i = 0; i < 3; i++) begin
            n_pos[i] = r_pos[i];
            n_vel[i] = r_vel[i];
            n_frc[i] = r_frc[i];
        end
        d = '0;
        if (i_cmd.load_op) begin
            for (int i = 0; i < 3; i++) begin
                unique case (r_op)
                    pps_pkg::OP_ADD_FORCE:
                        n_frc[i] = pps_pkg::sat32(66'(r_frc[i]) + 66'(r_vec[i]));
                    pps_pkg::OP_CLEAR_VEL: n_vel[i] = '0;
                    pps_pkg::OP_SET_POS:   n_pos[i] = r_vec[i];
                    default: n_pos[i] = r_pos[i];
                endcase
            end
        end
        if (i_cmd.weight && (r_pos[1] > r_floor)) begin
            n_frc[1] = pps_pkg::sat32(66'(r_frc[1]) - 66'($signed({1'b0, r_weight})));
        end
        if (i_cmd.axis_step) begin
            case (i_cmd.ustep)
                pps_pkg::US_DRAG3: begin
                    if (r_laminar) begin
                        d = pps_pkg::sat32(-66'(r_m));
                    end else begin
                        d = pps_pkg::sat32(-66'(pps_pkg::sat32(66'(r_m) * 66'sd25)));
                    end
                    n_frc[i_cmd.axis] =
                        pps_pkg::sat32(66'(r_frc[i_cmd.axis]) + 66'(d));
                end
                pps_pkg::US_POS: begin
                    n_pos[i_cmd.axis] = pps_pkg::sat32(66'(r_pos[i_cmd.axis])
                        + 66'(r_vdt) + 66'(r_prod));
                    n_vel[i_cmd.axis] = pps_pkg::sat32(66'(r_v) + 66'(r_ad));
                end
                default: ;
            endcase
        end
        if (i_cmd.walls) begin
            if (r_pos[1] < r_floor) begin
                n_vel[1] = '0;
                n_pos[1] = r_floor;
            end else if (r_pos[1] > pps_pkg::Q_CEILING) begin
                n_vel[1] = -pps_pkg::Q_HUNDREDTH;
            end
            if (r_pos[0] < -pps_pkg::Q_SIDE_WALL) begin
                n_vel[0] = pps_pkg::Q_HUNDREDTH;
            end else if (r_pos[0] > pps_pkg::Q_SIDE_WALL) begin
                n_vel[0] = -pps_pkg::Q_HUNDREDTH;
            end
            if (r_pos[2] < 0) begin
                n_vel[2] = pps_pkg::Q_HUNDREDTH;
            end else if (r_pos[2] > pps_pkg::Q_BACK_WALL) begin
                n_vel[2] = -pps_pkg::Q_HUNDREDTH;
            end
            for (int i = 0; i < 3; i++) begin
                n_frc[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] vv;
        vv = '0;
        if (!i_rst_n) begin
            r_laminar <= 1'b1;
            r_weight  <= '0;
            r_drag    <= '0;
            r_fric    <= '0;
            r_dt      <= 31'd1092;
            r_imass   <= 31'd1311;
            r_floor   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_frc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pps_pkg::REG_USE_LAMINAR: r_laminar <= i_cfg_data[0];
                    pps_pkg::REG_WEIGHT:      r_weight  <= i_cfg_data[30:0];
                    pps_pkg::REG_DRAG:        r_drag    <= i_cfg_data[30:0];
                    pps_pkg::REG_FRICTION:    r_fric    <= i_cfg_data[30:0];
                    pps_pkg::REG_TIME_STEP:   r_dt      <= i_cfg_data[30:0];
                    pps_pkg::REG_INV_MASS:    r_imass   <= i_cfg_data[30:0];
                    pps_pkg::REG_FLOOR:       r_floor   <= i_cfg_data;
                    default:                  r_laminar <= r_laminar;
                endcase
            end
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= n_pos[i];
                r_vel[i] <= n_vel[i];
                r_frc[i] <= n_frc[i];
            end
        end
        if (i_load) begin
            r_op     <= i_item.opcode;
            r_vec[0] <= i_item.vec_x;
            r_vec[1] <= i_item.vec_y;
            r_vec[2] <= i_item.vec_z;
        end
        r_prod <= w_pm;
        if (i_cmd.axis_step) begin
            case (i_cmd.ustep)
                pps_pkg::US_DRAG1: r_m <= w_pm;
                pps_pkg::US_DRAG2: r_m <= r_laminar ? r_m : w_pm;
                pps_pkg::US_ACCEL: r_a <= w_pm;
                pps_pkg::US_AD:    r_ad <= w_pm;
                pps_pkg::US_VEL: begin
                    vv = pps_pkg::sat32(66'(r_vel[i_cmd.axis]) + 66'(r_ad));
                    if (vv > 0) begin
                        r_v <= pps_pkg::sat32(66'(vv) - 66'($signed({1'b0, r_fric})));
                    end else if (vv < 0) begin
                        r_v <= pps_pkg::sat32(66'(vv) + 66'($signed({1'b0, r_fric})));
                    end else begin
                        r_v <= vv;
                    end
                end
                pps_pkg::US_VDT:   r_vdt <= w_pm;
                default:           r_a <= r_a;
            endcase
        end
    end

    assign o_opcode       = r_op;
    assign o_result.pos_x = r_pos[0];
    assign o_result.pos_y = r_pos[1];
    assign o_result.pos_z = r_pos[2];
    assign o_result.vel_x = r_vel[0];
    assign o_result.vel_y = r_vel[1];
    assign o_result.vel_z = r_vel[2];

endmodule

// ----- hw/rtl/pps_ctrl.sv -----
// Controller of the particle step block: sequences the per-axis micro-steps
// of a tick and the handshakes. Depends on pps_pkg.
module pps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic [1:0]     i_opcode,
    output logic           o_load,
    output pps_pkg::t_cmd  o_cmd
);

    pps_pkg::t_state r_state, n_state;
    pps_pkg::t_ustep r_ustep, n_ustep;
    logic [1:0]      r_axis, n_axis;
    logic            r_loaded, n_loaded;

    assign o_in_ready  = r_state == pps_pkg::ST_IDLE;
    assign o_out_valid = r_state == pps_pkg::ST_OUT;
    assign o_load      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_ustep  = r_ustep;
        n_axis   = r_axis;
        n_loaded = 1'b0;
        o_cmd    = '0;
        o_cmd.ustep = r_ustep;
        o_cmd.axis  = r_axis;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                if (o_load) begin
                    n_loaded = 1'b1;
                    n_state  = pps_pkg::ST_WEIGHT;
                end
            end
            pps_pkg::ST_WEIGHT: begin
                if (i_opcode == pps_pkg::OP_TICK) begin
                    o_cmd.weight = 1'b1;
                    n_state = pps_pkg::ST_AXIS;
                    n_ustep = pps_pkg::US_DRAG1;
                    n_axis  = 2'd0;
                end else begin
                    o_cmd.load_op = r_loaded;
                    n_state = pps_pkg::ST_OUT;
                end
            end
            pps_pkg::ST_AXIS: begin
                o_cmd.axis_step = 1'b1;
                if (r_ustep == pps_pkg::US_POS) begin
                    n_ustep = pps_pkg::US_DRAG1;
                    if (r_axis == 2'd2) begin
                        n_state = pps_pkg::ST_WALLS;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_ustep = pps_pkg::t_ustep'(r_ustep + 4'd1);
                end
            end
            pps_pkg::ST_WALLS: begin
                o_cmd.walls = 1'b1;
                n_state = pps_pkg::ST_OUT;
            end
            pps_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = pps_pkg::ST_IDLE;
                end
            end
            default: n_state = pps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::ST_IDLE;
            r_ustep  <= pps_pkg::US_DRAG1;
            r_axis   <= '0;
            r_loaded <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ustep  <= n_ustep;
            r_axis   <= n_axis;
            r_loaded <= n_loaded;
        end
    end

endmodule

// ----- hw/rtl/particle_physics_step.sv -----
// Top level of the particle step block: controller plus datapath.
// Depends on pps_pkg, pps_ctrl, pps_datapath and the macros header.
//
// Usage: an input beat carries an opcode and a Q16.16 vector. Add force,
// clear velocity and set position pass from accept through the weight
// state to a valid result. A tick runs nine micro-steps per axis on one
// shared 32x32 multiplier, then the wall step, before its result.
// One item is in work at a time; the next beat is accepted in the cycle
// after its result beat is taken. Each item gives one result beat with
// the position and velocity after it.
// When the receiver stalls, the result holds on the output and no new
// input is accepted. Reset clears the state vectors and loads the
// register defaults; configuration writes take effect at once. The user
// must make them only while the block is idle; nothing enforces it.
`include "particle_physics_step_macros.svh"
module particle_physics_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pps_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pps_pkg::t_out  o_out_data
);

    logic          w_load;
    logic [1:0]    w_opcode;
    pps_pkg::t_cmd w_cmd;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_opcode    (w_opcode),
        .o_load      (w_load),
        .o_cmd       (w_cmd)
    );

    pps_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (w_load),
        .i_item      (i_in_data),
        .i_cmd       (w_cmd),
        .o_opcode    (w_opcode),
        .o_result    (o_out_data)
    );

    `PPS_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `PPS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `PPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))

endmodule
